/* sv/nfa_wa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_wa_pkg
// Shared command codes, internal operation codes and the queue entry type
// of the NFA word acceptor.
// ----------------------------------------------------------------------------
package nfa_wa_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_EDGE  = 3'd1;
  localparam logic [2:0] CMD_FINAL = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_FEED  = 3'd4;

  // An edge labelled with this byte matches every fed symbol.
  localparam logic [7:0] WILDCARD_SYMBOL = 8'd46;

  // Operations after classification. Ignored commands become OP_NOP.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_EDGE,
    OP_WILD,
    OP_FINAL,
    OP_START,
    OP_FEED
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] from_st;
    logic [3:0] to_st;
    logic [7:0] sym;
    logic       sym_ok;   // fed symbol has a table row
    logic       flag;
  } item_t;

endpackage

/* sv/nfa_wa_if.sv */
// ----------------------------------------------------------------------------
// nfa_wa_if
// Valid/ready channels of the NFA word acceptor: command items in, status
// items out.
// ----------------------------------------------------------------------------
interface nfa_wa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] from_state;
  logic [3:0] to_state;
  logic [7:0] symbol;
  logic       final_flag;

  modport source (output valid, command, from_state, to_state, symbol, final_flag,
                  input ready);
  modport sink   (input valid, command, from_state, to_state, symbol, final_flag,
                  output ready);
endinterface

interface nfa_wa_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic alive;

  modport source (output valid, accepted, alive, input ready);
  modport sink   (input valid, accepted, alive, output ready);
endinterface

/* sv/nfa_wa_front.sv */
// ----------------------------------------------------------------------------
// nfa_wa_front
// Accepts command items, range-checks and classifies them, and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nfa_wa_front #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  nfa_wa_in_if.sink          in_ch,
  output logic               q_valid,
  input  logic               q_ready,
  output nfa_wa_pkg::item_t  q_item
);

  nfa_wa_pkg::item_t cls;
  nfa_wa_pkg::item_t q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;
  logic       from_ok, to_ok, sym_ok;

  assign from_ok = 32'(in_ch.from_state) < STATES;
  assign to_ok   = 32'(in_ch.to_state) < STATES;
  assign sym_ok  = 32'(in_ch.symbol) < SYMBOLS;

  always_comb begin
    cls.from_st = in_ch.from_state;
    cls.to_st   = in_ch.to_state;
    cls.sym     = in_ch.symbol;
    cls.sym_ok  = sym_ok;
    cls.flag    = in_ch.final_flag;
    cls.op      = nfa_wa_pkg::OP_NOP;
    case (in_ch.command)
      nfa_wa_pkg::CMD_CLEAR: cls.op = nfa_wa_pkg::OP_CLEAR;
      nfa_wa_pkg::CMD_EDGE: begin
        if (from_ok && to_ok) begin
          if (in_ch.symbol == nfa_wa_pkg::WILDCARD_SYMBOL) begin
            cls.op = nfa_wa_pkg::OP_WILD;
          end else if (sym_ok) begin
            cls.op = nfa_wa_pkg::OP_EDGE;
          end
        end
      end
      nfa_wa_pkg::CMD_FINAL: begin
        if (from_ok) cls.op = nfa_wa_pkg::OP_FINAL;
      end
      nfa_wa_pkg::CMD_START: cls.op = nfa_wa_pkg::OP_START;
      nfa_wa_pkg::CMD_FEED:  cls.op = nfa_wa_pkg::OP_FEED;
      default:               cls.op = nfa_wa_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (count_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* sv/nfa_wa_back.sv */
// ----------------------------------------------------------------------------
// nfa_wa_back
// Carries out classified items: the edge table memory access, the update
// of wildcard edges, final flags and the active set, and the result
// register.
// ----------------------------------------------------------------------------
module nfa_wa_back #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  nfa_wa_pkg::item_t  q_item,
  nfa_wa_out_if.source       out_ch
);

  localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int SAW   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ROW_W = STATES * STATES;
  localparam int BW    = $clog2(ROW_W);

  // One row per symbol, holding the target masks of every source state.
  logic [ROW_W-1:0]  mem [SYMBOLS];
  logic [SYMBOLS-1:0] row_vld_r;

  logic [STATES-1:0] wild_r [STATES];
  logic [STATES-1:0] fin_r, act_r;
  logic [STATES-1:0] fin_nxt, act_nxt, feed_set;

  nfa_wa_pkg::item_t a_item_r;
  logic              a_valid_r;
  logic [ROW_W-1:0]  a_row_r;
  logic              a_rvld_r;

  logic              out_valid_r, accepted_r, alive_r;
  logic              adv_out, load;
  logic [SAW-1:0]    addr;
  logic [BW-1:0]     bit_idx;
  logic [SW-1:0]     a_from, a_to;

  assign adv_out = !out_valid_r || out_ch.ready;
  assign load    = q_valid && (!a_valid_r || adv_out);
  assign q_ready = !a_valid_r || adv_out;

  assign addr    = SAW'(q_item.sym);
  assign bit_idx = BW'(int'(q_item.from_st) * STATES + int'(q_item.to_st));

  // Edge table: a row that is not valid since the last clear is treated as zero,
  // so the first edge written into it replaces the whole row.
  always_ff @(posedge clk) begin
    if (load && q_item.op == nfa_wa_pkg::OP_EDGE) begin
      if (row_vld_r[addr]) begin
        mem[addr][bit_idx] <= 1'b1;
      end else begin
        mem[addr] <= ROW_W'(1) << bit_idx;
      end
    end
    if (load) begin
      a_row_r  <= mem[addr];
      a_rvld_r <= row_vld_r[addr];
      a_item_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (load) begin
      if (q_item.op == nfa_wa_pkg::OP_CLEAR) begin
        row_vld_r <= '0;
      end else if (q_item.op == nfa_wa_pkg::OP_EDGE) begin
        row_vld_r[addr] <= 1'b1;
      end
    end
  end

  assign a_from = SW'(a_item_r.from_st);
  assign a_to   = SW'(a_item_r.to_st);

  always_comb begin
    feed_set = '0;
    for (int s = 0; s < STATES; s++) begin
      if (act_r[s]) begin
        feed_set = feed_set | wild_r[s];
        if (a_rvld_r && a_item_r.sym_ok) begin
          feed_set = feed_set | a_row_r[s*STATES +: STATES];
        end
      end
    end
  end

  always_comb begin
    act_nxt = act_r;
    fin_nxt = fin_r;
    case (a_item_r.op)
      nfa_wa_pkg::OP_CLEAR: begin
        act_nxt = STATES'(1);
        fin_nxt = '0;
      end
      nfa_wa_pkg::OP_FINAL: fin_nxt[a_from] = a_item_r.flag;
      nfa_wa_pkg::OP_START: act_nxt = STATES'(1);
      nfa_wa_pkg::OP_FEED:  act_nxt = feed_set;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= STATES'(1);
      fin_r       <= '0;
      for (int s = 0; s < STATES; s++) wild_r[s] <= '0;
    end else begin
      if (load) begin
        a_valid_r <= 1'b1;
      end else if (adv_out) begin
        a_valid_r <= 1'b0;
      end
      if (adv_out) out_valid_r <= a_valid_r;
      if (a_valid_r && adv_out) begin
        act_r <= act_nxt;
        fin_r <= fin_nxt;
        if (a_item_r.op == nfa_wa_pkg::OP_CLEAR) begin
          for (int s = 0; s < STATES; s++) wild_r[s] <= '0;
        end else if (a_item_r.op == nfa_wa_pkg::OP_WILD) begin
          wild_r[a_from][a_to] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && adv_out) begin
      accepted_r <= |(act_nxt & fin_nxt);
      alive_r    <= |act_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = accepted_r;
  assign out_ch.alive    = alive_r;

endmodule

/* sv/nfa_word_acceptor.sv */
// ----------------------------------------------------------------------------
// nfa_word_acceptor
// Nondeterministic finite automaton matcher over byte symbols, with edge,
// final-flag, word-start and feed commands and one status item per command.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle while the output side
// is not stalled, and returns one status item (accepted, alive) for each,
// in order. The rate is set by the edge table: a single-port memory of
// SYMBOLS rows, each holding the STATES x STATES target masks of one
// symbol, so a fed symbol needs exactly one row read and an added edge
// exactly one row write. A clear writes no memory row: each row carries a
// valid bit in flip-flops, cleared at once, so no clearing pass over the
// memory is needed after reset or a clear command.
//
// Structure: the front end classifies items (range checks, wildcard
// labels, unused command codes) into a two-entry queue. The back end reads
// or writes the edge table on its first stage, then forms the new active
// set from the row, the wildcard edges and the current set, and registers
// the result. The queue lets the input side keep flowing for two items
// while the result side stalls.
// ----------------------------------------------------------------------------
module nfa_word_acceptor #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  nfa_wa_in_if.sink    in_ch,
  nfa_wa_out_if.source out_ch
);

  // Classified items travel from the front end to the back end through
  // this handshake.
  logic              q_valid;
  logic              q_ready;
  nfa_wa_pkg::item_t q_item;

  nfa_wa_front #(
    .STATES  (STATES),
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  nfa_wa_back #(
    .STATES  (STATES),
    .SYMBOLS (SYMBOLS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

  // A word can only be accepted while some state is still active.
  a_accept_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.accepted || out_ch.alive))
    else $error("accepted reported for a dead word");

  // The front end only refuses items while its queue holds something.
  a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  // A queued item that the back end does not take stays queued.
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_ready) |=> (q_valid && $stable(q_item)))
    else $error("queued item lost or changed while stalled");

  // The back end cannot refuse queue items while its result side is free.
  a_back_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.ready || !out_ch.valid) |-> q_ready)
    else $error("back end stalled with a free result register");

endmodule

/* test/nfa_word_acceptor_test.sv */
// ----------------------------------------------------------------------------
// nfa_word_acceptor_test
// Self-checking bench for the NFA word acceptor. Command items go in through
// a bursty sender, and a stalling receiver takes the status items. Every
// status item is compared against a behavioral automaton kept in the bench.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_STATES  = 16;
  localparam int N_SYMBOLS = 256;

  // Command codes that the block does not define. They must leave the
  // automaton untouched and still answer with the current word status.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // The random word phase stops once this many items have gone in, and the
  // random command phase then adds a fixed number of items of pure noise.
  localparam int WORD_PHASE_ITEMS  = 1300;
  localparam int NOISE_PHASE_ITEMS = 300;

  // Receiver behavior: always ready, ready on a coin flip, or long holds.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_HOLD
  } rx_mode_t;

  typedef struct packed {
    logic accepted;
    logic alive;
  } word_status_t;

  logic clk;
  logic rst_n;

  nfa_wa_in_if  in_ch ();
  nfa_wa_out_if out_ch ();

  nfa_word_acceptor #(
    .STATES (N_STATES),
    .SYMBOLS(N_SYMBOLS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // --------------------------------------------------------------------------
  // Behavioral automaton. One target mask per (state, label byte), one mask
  // of wildcard targets per state, the accepting states and the set of
  // states the current word can be in.
  // --------------------------------------------------------------------------
  logic [N_STATES-1:0] label_dest [N_STATES][N_SYMBOLS];
  logic [N_STATES-1:0] any_dest   [N_STATES];
  logic [N_STATES-1:0] accepting;
  logic [N_STATES-1:0] current_states;

  // Status items predicted for accepted commands, kept in a small ring.
  // Far fewer than sixteen items are ever in flight inside the block.
  word_status_t pending_status [16];
  logic [3:0]   status_wr_ptr;
  logic [3:0]   status_rd_ptr;

  int unsigned items_sent;
  int unsigned items_checked;
  int unsigned error_count;
  int unsigned burst_left;

  // Clearing the automaton forgets every edge and final flag and puts the
  // word back at its start.
  function void wipe_automaton();
    for (int s = 0; s < N_STATES; s++) begin
      for (int c = 0; c < N_SYMBOLS; c++) begin
        label_dest[s][c] = '0;
      end
      any_dest[s] = '0;
    end
    accepting      = '0;
    current_states = N_STATES'(1);
  endfunction

  // Applies one command to the automaton and queues the status item that
  // the block has to return for it.
  function void step_automaton(input logic [2:0] cmd, input logic [3:0] from_st,
                               input logic [3:0] to_st, input logic [7:0] sym,
                               input logic flag);
    logic [N_STATES-1:0] reached;
    word_status_t        status;
    reached = '0;
    case (cmd)
      nfa_wa_pkg::CMD_CLEAR: begin
        wipe_automaton();
      end
      nfa_wa_pkg::CMD_EDGE: begin
        // Labels accumulate; the wildcard byte only ever lands in the
        // wildcard masks, never in the label table.
        if (from_st < N_STATES && to_st < N_STATES) begin
          if (sym == nfa_wa_pkg::WILDCARD_SYMBOL) begin
            any_dest[from_st][to_st] = 1'b1;
          end else if (sym < N_SYMBOLS) begin
            label_dest[from_st][sym][to_st] = 1'b1;
          end
        end
      end
      nfa_wa_pkg::CMD_FINAL: begin
        if (from_st < N_STATES) begin
          accepting[from_st] = flag;
        end
      end
      nfa_wa_pkg::CMD_START: begin
        current_states = N_STATES'(1);
      end
      nfa_wa_pkg::CMD_FEED: begin
        // An empty set stays empty, since no state contributes targets.
        for (int s = 0; s < N_STATES; s++) begin
          if (current_states[s]) begin
            reached |= any_dest[s];
            if (sym < N_SYMBOLS) begin
              reached |= label_dest[s][sym];
            end
          end
        end
        current_states = reached;
      end
      default: begin
      end
    endcase
    status.accepted = |(current_states & accepting);
    status.alive    = |current_states;
    pending_status[status_wr_ptr] = status;
    status_wr_ptr = status_wr_ptr + 4'd1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts the
  // valid line may drop for a random gap. Now and then a long burst gives a
  // stretch without any gap. The prediction is made at the edge where the
  // item is accepted.
  // --------------------------------------------------------------------------
  task send_item(input logic [2:0] cmd, input logic [3:0] from_st, input logic [3:0] to_st,
                 input logic [7:0] sym, input logic flag);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 10);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.from_state <= from_st;
    in_ch.to_state   <= to_st;
    in_ch.symbol     <= sym;
    in_ch.final_flag <= flag;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    step_automaton(cmd, from_st, to_st, sym, flag);
    items_sent++;
    burst_left--;
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker. The values seen at a rising edge are the ones that
  // were present before it, so the handshake is judged on them; ready for
  // the next edge is chosen afterwards.
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_hold_left;

  always @(posedge clk) begin
    word_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (items_checked == items_sent) begin
        $error("status item with nothing pending: accepted=%0b alive=%0b",
               out_ch.accepted, out_ch.alive);
        error_count++;
      end else begin
        want = pending_status[status_rd_ptr];
        status_rd_ptr = status_rd_ptr + 4'd1;
        items_checked++;
        if (out_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0b, actual %0b", want.accepted, out_ch.accepted);
          error_count++;
        end
        if (out_ch.alive !== want.alive) begin
          $error("alive: expected %0b, actual %0b", want.alive, out_ch.alive);
          error_count++;
        end
      end
    end

    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_STEADY: begin
        out_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_hold_left != 0) begin
          out_ch.ready <= 1'b0;
          rx_hold_left--;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            rx_hold_left = $urandom_range(1, 8);
          end
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Right after reset the word sits in state 0, which is not final. The
  // spare command codes then have to report that status unchanged.
  task test_reset_and_spare_codes();
    send_item(nfa_wa_pkg::CMD_START, 4'd0, 4'd0, 8'd0, 1'b0);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      send_item(3'(c), 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // A small hand-built automaton that uses the extreme states and bytes,
  // a wildcard edge, a fed wildcard byte, a dying word, restart and clear.
  task test_directed_automaton();
    send_item(nfa_wa_pkg::CMD_FINAL, 4'd0, 4'd0, 8'd0, 1'b1);   // empty word accepted
    send_item(nfa_wa_pkg::CMD_START, 4'd0, 4'd0, 8'd0, 1'b0);
    send_item(nfa_wa_pkg::CMD_EDGE, 4'd0, 4'd15, 8'd0, 1'b0);
    send_item(nfa_wa_pkg::CMD_EDGE, 4'd15, 4'd15, 8'd255, 1'b0);
    send_item(nfa_wa_pkg::CMD_EDGE, 4'd15, 4'd0, nfa_wa_pkg::WILDCARD_SYMBOL, 1'b0);
    send_item(nfa_wa_pkg::CMD_FINAL, 4'd15, 4'd0, 8'd0, 1'b1);
    send_item(nfa_wa_pkg::CMD_FINAL, 4'd0, 4'd0, 8'd0, 1'b0);   // state 0 no longer final
    send_item(nfa_wa_pkg::CMD_START, 4'd0, 4'd0, 8'd0, 1'b0);
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd0, 1'b0);    // reaches state 15
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd255, 1'b0);  // self loop plus wildcard
    // A fed wildcard byte only follows wildcard edges.
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, nfa_wa_pkg::WILDCARD_SYMBOL, 1'b0);
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd7, 1'b0);    // no edge: the word dies
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd0, 1'b0);    // and stays dead
    send_item(nfa_wa_pkg::CMD_START, 4'd0, 4'd0, 8'd0, 1'b0);
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd0, 1'b0);    // edges survive a restart
    send_item(nfa_wa_pkg::CMD_CLEAR, 4'd15, 4'd15, 8'd255, 1'b1);
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd0, 1'b0);    // all edges gone
    send_item(nfa_wa_pkg::CMD_EDGE, 4'd0, 4'd0, nfa_wa_pkg::WILDCARD_SYMBOL, 1'b0);
    send_item(nfa_wa_pkg::CMD_START, 4'd0, 4'd0, 8'd0, 1'b0);
    send_item(nfa_wa_pkg::CMD_FEED, 4'd0, 4'd0, 8'd200, 1'b0);
  endtask

  // Well-formed rounds: usually a clear, then a random automaton over a
  // four-byte alphabet with some wildcard edges and final flags, then a few
  // words of random content. Occasional stray bytes in the words exercise
  // the path where only wildcard edges match.
  task test_random_words();
    int unsigned n_st;
    logic [7:0]  base;
    logic [7:0]  sym;
    while (items_sent < WORD_PHASE_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        send_item(nfa_wa_pkg::CMD_CLEAR, 4'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom));
      end
      n_st = $urandom_range(2, N_STATES);
      base = 8'($urandom_range(0, 252));
      repeat ($urandom_range(1, 2 * n_st)) begin
        sym = ($urandom_range(0, 7) == 0) ? nfa_wa_pkg::WILDCARD_SYMBOL
                                          : base + 8'($urandom_range(0, 3));
        send_item(nfa_wa_pkg::CMD_EDGE, 4'($urandom_range(0, n_st - 1)),
                  4'($urandom_range(0, n_st - 1)), sym, 1'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
        send_item(nfa_wa_pkg::CMD_FINAL, 4'($urandom_range(0, n_st - 1)), 4'($urandom),
                  8'($urandom), 1'($urandom_range(0, 3) != 0));
      end
      repeat ($urandom_range(1, 4)) begin
        send_item(nfa_wa_pkg::CMD_START, 4'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom));
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 9))
            0:       sym = 8'($urandom);
            1:       sym = nfa_wa_pkg::WILDCARD_SYMBOL;
            default: sym = base + 8'($urandom_range(0, 3));
          endcase
          send_item(nfa_wa_pkg::CMD_FEED, 4'($urandom), 4'($urandom), sym, 1'($urandom));
        end
      end
    end
  endtask

  // Unstructured commands with every field random, spare codes included.
  task test_random_commands();
    repeat (NOISE_PHASE_ITEMS) begin
      send_item(3'($urandom_range(nfa_wa_pkg::CMD_CLEAR, CMD_SPARE_LAST)), 4'($urandom),
                4'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and test sequence.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = nfa_wa_pkg::CMD_START;
    in_ch.from_state = '0;
    in_ch.to_state   = '0;
    in_ch.symbol     = '0;
    in_ch.final_flag = 1'b0;
    out_ch.ready     = 1'b0;
    rx_mode          = RX_STEADY;
    rx_mode_left     = 0;
    rx_hold_left     = 0;
    items_sent       = 0;
    items_checked    = 0;
    status_wr_ptr    = '0;
    status_rd_ptr    = '0;
    error_count      = 0;
    burst_left       = 0;
    wipe_automaton();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_and_spare_codes();
    test_directed_automaton();
    test_random_words();
    test_random_commands();
    in_ch.valid <= 1'b0;

    // Drain the pending status items, then keep watching the output so that
    // any extra item from the block would still be caught.
    while (items_checked != items_sent) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about two thousand
  // items with full gaps and stalls.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* nfa_word_acceptor.f */
sv/nfa_wa_pkg.sv
sv/nfa_wa_if.sv
sv/nfa_wa_front.sv
sv/nfa_wa_back.sv
sv/nfa_word_acceptor.sv
test/nfa_word_acceptor_test.sv
